[rtl/core/oledc_pkg.sv]
package oledc_pkg;

  // defaults for the top level parameters
  localparam int DISPLAY_WIDTH_DEF = 128;
  localparam int STORE_BYTES_DEF   = 1024;

  // fixed field widths
  localparam int ADDR_W   = 10;
  localparam int HEIGHT_W = 7;

  // queue between decoder and store
  localparam int QUEUE_DEPTH = 4;
  // result queue slots
  localparam int OUT_DEPTH = 2;

  // packet kinds
  localparam logic [1:0] KIND_IGNORE  = 2'd0;
  localparam logic [1:0] KIND_COMMAND = 2'd1;
  localparam logic [1:0] KIND_DATA    = 2'd2;

  // pending command opcodes
  localparam logic [1:0] OP_COLUMN = 2'd0;
  localparam logic [1:0] OP_PAGE   = 2'd1;
  localparam logic [1:0] OP_MODE   = 2'd2;
  localparam logic [1:0] OP_MUX    = 2'd3;

  // control bytes
  localparam logic [7:0] CTRL_CMD      = 8'h00;
  localparam logic [7:0] CTRL_CMD_CONT = 8'h80;
  localparam logic [7:0] CTRL_DATA     = 8'h40;

  // command bytes
  localparam logic [7:0] CMD_COLUMN = 8'h21;
  localparam logic [7:0] CMD_PAGE   = 8'h22;
  localparam logic [7:0] CMD_MODE   = 8'h20;
  localparam logic [7:0] CMD_MUX    = 8'hA8;

  localparam logic [7:0] MUX_ARG_32      = 8'd31;
  localparam logic [7:0] MODE_HORIZONTAL = 8'h00;

  localparam logic [HEIGHT_W-1:0] HEIGHT_32 = 7'd32;
  localparam logic [HEIGHT_W-1:0] HEIGHT_64 = 7'd64;
  localparam logic [7:0] PAGE_END_32 = 8'd3;
  localparam logic [7:0] PAGE_END_64 = 8'd7;

  typedef struct packed {
    logic              func;
    logic              packet_first;
    logic [1:0]        bytes_following;
    logic [7:0]        bus_byte;
    logic [ADDR_W-1:0] read_address;
  } in_t;

  typedef struct packed {
    logic [7:0]          read_byte;
    logic [HEIGHT_W-1:0] display_height;
  } out_t;

  // one store operation from the decoder
  typedef struct packed {
    logic                is_read;
    logic                zero;
    logic [ADDR_W-1:0]   addr;
    logic [7:0]          data;
    logic [HEIGHT_W-1:0] height;
  } op_t;

endpackage

[rtl/core/oledc_front.sv]
module oledc_front #(
  parameter int DISPLAY_WIDTH = 128,
  parameter int STORE_BYTES   = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  oledc_pkg::in_t item,
  output logic           enq_valid,
  output oledc_pkg::op_t enq_op
);
  import oledc_pkg::*;

  localparam int OFF_W = 17;

  logic [1:0]          packet_kind, packet_kind_next;
  logic [1:0]          pending_opcode, pending_opcode_next;
  logic [1:0]          arguments_left, arguments_left_next;
  logic [7:0]          first_argument, first_argument_next;
  logic [HEIGHT_W-1:0] height_lines, height_lines_next;
  logic [7:0]          column_start, column_start_next;
  logic [7:0]          column_end, column_end_next;
  logic [7:0]          column_cursor, column_cursor_next;
  logic [7:0]          page_start, page_start_next;
  logic [7:0]          page_end, page_end_next;
  logic [7:0]          page_cursor, page_cursor_next;
  logic [7:0]          addressing_mode, addressing_mode_next;

  logic [OFF_W-1:0] offset;
  logic             in_store;
  logic [7:0]       col_inc, pg_inc;
  logic             ge1, ge2;

  assign offset   = OFF_W'(page_cursor) * OFF_W'(DISPLAY_WIDTH) + OFF_W'(column_cursor);
  assign in_store = offset < OFF_W'(STORE_BYTES);
  assign col_inc  = column_cursor + 8'd1;
  assign pg_inc   = page_cursor + 8'd1;
  // saturating bytes_following only matters through these two tests
  assign ge1      = item.bytes_following != 2'd0;
  assign ge2      = item.bytes_following[1];

  always_comb begin
    packet_kind_next     = packet_kind;
    pending_opcode_next  = pending_opcode;
    arguments_left_next  = arguments_left;
    first_argument_next  = first_argument;
    height_lines_next    = height_lines;
    column_start_next    = column_start;
    column_end_next      = column_end;
    column_cursor_next   = column_cursor;
    page_start_next      = page_start;
    page_end_next        = page_end;
    page_cursor_next     = page_cursor;
    addressing_mode_next = addressing_mode;
    enq_valid            = 1'b0;
    enq_op.is_read       = item.func;
    enq_op.zero          = !(OFF_W'(item.read_address) < OFF_W'(STORE_BYTES));
    enq_op.addr          = item.func ? item.read_address : offset[ADDR_W-1:0];
    enq_op.data          = item.bus_byte;
    enq_op.height        = height_lines;

    if (accept) begin
      if (item.func) begin
        enq_valid = 1'b1;
      end else if (item.packet_first) begin
        arguments_left_next = 2'd0;
        if (!ge1) begin
          packet_kind_next = KIND_IGNORE;
        end else if (item.bus_byte == CTRL_CMD || item.bus_byte == CTRL_CMD_CONT) begin
          packet_kind_next = KIND_COMMAND;
        end else if (item.bus_byte == CTRL_DATA) begin
          packet_kind_next = KIND_DATA;
        end else begin
          packet_kind_next = KIND_IGNORE;
        end
      end else if (packet_kind == KIND_COMMAND) begin
        if (arguments_left != 2'd0) begin
          // argument byte of a pending command
          arguments_left_next = 2'd0;
          unique case (pending_opcode)
            OP_COLUMN, OP_PAGE: begin
              if (arguments_left == 2'd2) begin
                first_argument_next = item.bus_byte;
                arguments_left_next = 2'd1;
              end else if (pending_opcode == OP_COLUMN) begin
                column_start_next  = first_argument;
                column_end_next    = item.bus_byte;
                column_cursor_next = first_argument;
              end else begin
                page_start_next  = first_argument;
                page_end_next    = item.bus_byte;
                page_cursor_next = first_argument;
              end
            end
            OP_MODE: addressing_mode_next = item.bus_byte;
            OP_MUX: begin
              if (item.bus_byte == MUX_ARG_32) begin
                height_lines_next = HEIGHT_32;
                page_end_next     = PAGE_END_32;
              end else begin
                height_lines_next = HEIGHT_64;
                page_end_next     = PAGE_END_64;
              end
            end
            default: ;
          endcase
        end else begin
          // commands whose arguments do not fit are skipped
          priority if (item.bus_byte == CMD_COLUMN && ge2) begin
            pending_opcode_next = OP_COLUMN;
            arguments_left_next = 2'd2;
          end else if (item.bus_byte == CMD_PAGE && ge2) begin
            pending_opcode_next = OP_PAGE;
            arguments_left_next = 2'd2;
          end else if (item.bus_byte == CMD_MODE && ge1) begin
            pending_opcode_next = OP_MODE;
            arguments_left_next = 2'd1;
          end else if (item.bus_byte == CMD_MUX && ge1) begin
            pending_opcode_next = OP_MUX;
            arguments_left_next = 2'd1;
          end else begin
          end
        end
      end else if (packet_kind == KIND_DATA) begin
        enq_valid = in_store;
        if (addressing_mode == MODE_HORIZONTAL) begin
          if (col_inc > column_end) begin
            column_cursor_next = column_start;
            page_cursor_next   = (pg_inc > page_end) ? page_start : pg_inc;
          end else begin
            column_cursor_next = col_inc;
          end
        end else begin
          column_cursor_next = ({1'b0, col_inc} >= 9'(DISPLAY_WIDTH)) ? 8'd0 : col_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_kind     <= KIND_IGNORE;
      pending_opcode  <= OP_COLUMN;
      arguments_left  <= 2'd0;
      first_argument  <= 8'd0;
      height_lines    <= HEIGHT_64;
      column_start    <= 8'd0;
      column_end      <= 8'd127;
      column_cursor   <= 8'd0;
      page_start      <= 8'd0;
      page_end        <= PAGE_END_64;
      page_cursor     <= 8'd0;
      addressing_mode <= MODE_HORIZONTAL;
    end else begin
      packet_kind     <= packet_kind_next;
      pending_opcode  <= pending_opcode_next;
      arguments_left  <= arguments_left_next;
      first_argument  <= first_argument_next;
      height_lines    <= height_lines_next;
      column_start    <= column_start_next;
      column_end      <= column_end_next;
      column_cursor   <= column_cursor_next;
      page_start      <= page_start_next;
      page_end        <= page_end_next;
      page_cursor     <= page_cursor_next;
      addressing_mode <= addressing_mode_next;
    end
  end

endmodule

[rtl/core/oledc_queue.sv]
module oledc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  oledc_pkg::op_t push_op,
  output logic           full,
  input  logic           pop,
  output oledc_pkg::op_t pop_op,
  output logic           empty
);
  import oledc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = count == CNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_op  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

[rtl/core/oledc_back.sv]
module oledc_back #(
  parameter int STORE_BYTES = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  oledc_pkg::op_t  q_op,
  output logic            q_pop,
  output logic            busy,
  output logic            empty,
  input  logic            pop,
  output oledc_pkg::out_t result
);
  import oledc_pkg::*;

  localparam int IDX_W = $clog2(STORE_BYTES);
  localparam int OCC_W = $clog2(OUT_DEPTH + 2);

  logic [7:0]          mem [STORE_BYTES];
  logic                clearing;
  logic [IDX_W-1:0]    clr_idx;

  logic                take, take_read;
  logic                we;
  logic [IDX_W-1:0]    wa;
  logic [7:0]          wd;

  logic [7:0]          rd_data;
  logic                rd_zero;
  logic [HEIGHT_W-1:0] rd_height;
  logic                inflight;

  out_t                out_q [OUT_DEPTH];
  logic                out_head;
  logic [1:0]          out_count;
  logic                pop_fire;
  logic [OCC_W-1:0]    occ;
  logic                can_read;

  assign busy      = clearing;
  assign pop_fire  = pop && out_count != 2'd0;
  assign occ       = OCC_W'(out_count) + OCC_W'(inflight);
  assign can_read  = occ < OCC_W'(OUT_DEPTH) + OCC_W'(pop_fire);
  assign take      = !clearing && !q_empty && (!q_op.is_read || can_read);
  assign take_read = take && q_op.is_read;
  assign q_pop     = take;

  assign we = clearing || (take && !q_op.is_read);
  assign wa = clearing ? clr_idx : q_op.addr[IDX_W-1:0];
  assign wd = clearing ? 8'd0 : q_op.data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (take_read) begin
      rd_data   <= mem[q_op.addr[IDX_W-1:0]];
      rd_zero   <= q_op.zero;
      rd_height <= q_op.height;
    end
  end

  always_ff @(posedge clk) begin
    if (inflight) begin
      out_q[out_head ^ out_count[0]].read_byte      <= rd_zero ? 8'd0 : rd_data;
      out_q[out_head ^ out_count[0]].display_height <= rd_height;
    end
  end

  assign empty  = out_count == 2'd0;
  assign result = out_q[out_head];

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_idx   <= '0;
      inflight  <= 1'b0;
      out_head  <= 1'b0;
      out_count <= 2'd0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + IDX_W'(1);
        if (clr_idx == IDX_W'(STORE_BYTES - 1)) begin
          clearing <= 1'b0;
        end
      end
      inflight <= take_read;
      if (pop_fire) begin
        out_head <= !out_head;
      end
      out_count <= out_count + 2'(inflight) - 2'(pop_fire);
    end
  end

endmodule

[rtl/core/oled_controller_command_and_gram.sv]
// monochrome oled controller: command decoder and page-organized pixel memory
//
// input channel (push/full, item): one word per bus byte or per read request.
//   item.func = 0 carries one byte of a bus write packet, item.packet_first
//   marks the control byte, item.bytes_following the bytes still to come.
//   item.func = 1 asks for the stored byte at item.read_address.
// result channel (empty/pop, result): one word per read request, in order,
//   holding the stored byte and the display height at the time of the read.
// timing: a read word reaches result through the decoder queue, the
//   registered memory read and a result slot. one word can be accepted
//   every cycle while full is low, writes and reads alike; the single
//   memory port does one write or one read per cycle.
// reset: rst clears the decoder state to its default ranges and then the
//   memory is swept to zero, one byte per cycle over every address; full
//   stays high during that sweep.
// stall: while pop is low the two result slots fill, reads stop at the
//   memory, the decoder queue fills, and then full rises. byte writes queued
//   behind a waiting read stay in the queue with it, in order.
module oled_controller_command_and_gram #(
  parameter int DISPLAY_WIDTH = oledc_pkg::DISPLAY_WIDTH_DEF,
  parameter int STORE_BYTES   = oledc_pkg::STORE_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  oledc_pkg::in_t  item,
  output logic            empty,
  input  logic            pop,
  output oledc_pkg::out_t result
);
  import oledc_pkg::*;

  logic accept;
  logic enq_valid;
  op_t  enq_op;
  logic q_full, q_empty, q_pop;
  op_t  q_op;
  logic busy;

  // no word is taken while the memory sweep runs or the queue has no room
  assign full   = busy || q_full;
  assign accept = push && !full;

  // front: decodes packets, owns cursors and ranges, emits store operations
  oledc_front #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .STORE_BYTES   (STORE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .enq_valid (enq_valid),
    .enq_op    (enq_op)
  );

  // short queue so the front keeps going while reads wait on the receiver
  oledc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (enq_valid),
    .push_op (enq_op),
    .full    (q_full),
    .pop     (q_pop),
    .pop_op  (q_op),
    .empty   (q_empty)
  );

  // back: pixel memory, clear sweep and result slots
  oledc_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_op    (q_op),
    .q_pop   (q_pop),
    .busy    (busy),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

[rtl/core/oledc_checker.sv]
module oledc_checker (
  input logic            clk,
  input logic            rst,
  input logic            full,
  input logic            empty,
  input logic            pop,
  input oledc_pkg::out_t result
);
  import oledc_pkg::*;

  // reset starts the memory sweep, so no word is taken right after it
  a_full_after_reset: assert property (@(posedge clk) rst |=> full)
    else $error("full low right after reset");

  // no result survives reset
  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // height is only ever 32 or 64
  a_height_legal: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.display_height == HEIGHT_32 || result.display_height == HEIGHT_64))
    else $error("illegal display height");

  // a waiting result holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("result changed while stalled");

endmodule

bind oled_controller_command_and_gram oledc_checker u_checker (.*);
